@@ design/mpwu_pkg.sv @@
// Shared types and constants of the magic pixel write unit.
package mpwu_pkg;

  localparam int unsigned ADDR_W     = 14;
  localparam int unsigned ADDR_EXT_W = 17;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned CTRL_W     = 7;
  localparam int unsigned COLOR_W    = 4;

  // bus operation codes
  localparam logic [OP_W-1:0] OP_MAGIC    = 3'd0;
  localparam logic [OP_W-1:0] OP_RAM_WR   = 3'd1;
  localparam logic [OP_W-1:0] OP_RAM_RD   = 3'd2;
  localparam logic [OP_W-1:0] OP_CTRL_WR  = 3'd3;
  localparam logic [OP_W-1:0] OP_COLOR_WR = 3'd4;
  localparam logic [OP_W-1:0] OP_COLL_RD  = 3'd5;

  // draw control bit positions
  localparam int unsigned CTL_EXPAND = 3;
  localparam int unsigned CTL_OR     = 4;
  localparam int unsigned CTL_XOR    = 5;
  localparam int unsigned CTL_FLIP   = 6;

  localparam logic [DATA_W-1:0] COLL_HIT  = 8'hff;
  localparam logic [DATA_W-1:0] COLL_KEEP = 8'h0f;

  typedef enum logic [2:0] {
    K_NOP,
    K_MAGIC,
    K_RAM_WR,
    K_RAM_RD,
    K_CTRL_WR,
    K_COLOR_WR,
    K_COLL_RD
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic               in_range;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  data;
  } entry_t;

  function automatic logic [ADDR_EXT_W-1:0] addr_ext(input logic [ADDR_W-1:0] a);
    addr_ext = {{(ADDR_EXT_W-ADDR_W){1'b0}}, a};
  endfunction

  function automatic logic [DATA_W-1:0] reverse_pixels(input logic [DATA_W-1:0] d);
    reverse_pixels = {d[1:0], d[3:2], d[5:4], d[7:6]};
  endfunction

endpackage

@@ design/magic_pixel_write_unit.sv @@
// Top level of the magic pixel write unit.
// Each bus word (op, address, write_data) gives exactly one result word
// (read_data), in order. The back end takes a new word only once the last
// one is done: it does a read-modify-write of the single-port video RAM,
// first reading the byte, then merging, writing it and posting the result.
// A word passes the queue, the RAM read and exec registers and the result
// register. A 2-word queue in the front end keeps taking words while the
// back end works or while a finished result waits on out_stall_i. After
// reset the video RAM is swept to zero, one byte per cycle, and in_stall_o
// stays high until the sweep ends. Magic writes expand,
// flip and shift pixels per the draw control register, carry shifted-out
// pixels into the next magic write, and update the collision latch in OR
// or XOR mode. Addresses at or beyond RAM_BYTES read as zero and drop
// writes. Ops 6 and 7 do nothing and return zero.
module magic_pixel_write_unit #(
  parameter int unsigned RAM_BYTES = 16384
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mpwu_pkg::OP_W-1:0]      op_i,
  input  logic [mpwu_pkg::ADDR_W-1:0]    address_i,
  input  logic [mpwu_pkg::DATA_W-1:0]    write_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mpwu_pkg::DATA_W-1:0]    read_data_o
);
  import mpwu_pkg::*;

  logic   busy;     // RAM clearing sweep in progress
  logic   q_valid;
  logic   q_pop;
  entry_t q_head;

  // front: decode and queue
  mpwu_front #(
    .RAM_BYTES (RAM_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .busy_i       (busy),
    .q_valid_o    (q_valid),
    .q_head_o     (q_head),
    .q_pop_i      (q_pop)
  );

  // back: RAM, draw state, result register
  mpwu_back #(
    .RAM_BYTES (RAM_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .busy_o      (busy),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o)
  );

endmodule

@@ design/mpwu_front.sv @@
// Front end: accepts bus words, classifies them and queues them for the back end.
module mpwu_front #(
  parameter int unsigned RAM_BYTES = 16384
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mpwu_pkg::OP_W-1:0]      op_i,
  input  logic [mpwu_pkg::ADDR_W-1:0]    address_i,
  input  logic [mpwu_pkg::DATA_W-1:0]    write_data_i,
  input  logic                           busy_i,
  output logic                           q_valid_o,
  output mpwu_pkg::entry_t               q_head_o,
  input  logic                           q_pop_i
);
  import mpwu_pkg::*;

  entry_t      ent_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  entry_t      new_ent;

  assign in_stall_o = (cnt_q == 2'd2) || busy_i;
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_head_o   = ent_q[rd_ptr_q];

  always_comb begin
    case (op_i)
      OP_MAGIC:    new_ent.kind = K_MAGIC;
      OP_RAM_WR:   new_ent.kind = K_RAM_WR;
      OP_RAM_RD:   new_ent.kind = K_RAM_RD;
      OP_CTRL_WR:  new_ent.kind = K_CTRL_WR;
      OP_COLOR_WR: new_ent.kind = K_COLOR_WR;
      OP_COLL_RD:  new_ent.kind = K_COLL_RD;
      default:     new_ent.kind = K_NOP;
    endcase
    new_ent.in_range = addr_ext(address_i) < ADDR_EXT_W'(RAM_BYTES);
    new_ent.addr     = address_i;
    new_ent.data     = write_data_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= new_ent;
    end
  end

endmodule

@@ design/mpwu_back.sv @@
// Back end: video RAM, draw state and read-modify-write execution.
module mpwu_back #(
  parameter int unsigned RAM_BYTES = 16384
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  output logic                           busy_o,
  input  logic                           q_valid_i,
  input  mpwu_pkg::entry_t               q_head_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mpwu_pkg::DATA_W-1:0]    read_data_o
);
  import mpwu_pkg::*;

  localparam int unsigned AW = $clog2(RAM_BYTES);

  logic [DATA_W-1:0]  mem [RAM_BYTES];
  logic [DATA_W-1:0]  rd_q;

  logic               clr_busy_q;
  logic [AW-1:0]      clr_addr_q;

  logic               exec_valid_q;
  entry_t             exec_q;

  logic [CTRL_W-1:0]  ctrl_q;
  logic [COLOR_W-1:0] colors_q;
  logic               phase_q;
  logic [DATA_W-1:0]  carry_q;
  logic [DATA_W-1:0]  coll_q;

  logic               out_valid_q;
  logic [DATA_W-1:0]  read_data_q;

  logic               done;
  logic [ADDR_EXT_W-1:0] exec_ext, head_ext;
  logic [AW-1:0]      exec_idx, head_idx;
  logic [DATA_W-1:0]  old_byte;
  logic [DATA_W-1:0]  pix, shifted, spill, merged, wr_byte, result;
  logic [DATA_W-1:0]  coll_d;
  logic [3:0]         nib;
  logic [1:0]         sh;
  logic [2*DATA_W-1:0] wide;
  logic               wr_en;

  assign busy_o      = clr_busy_q;
  assign q_pop_o     = q_valid_i && !exec_valid_q && !clr_busy_q;
  assign done        = exec_valid_q && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

  assign exec_ext = addr_ext(exec_q.addr);
  assign head_ext = addr_ext(q_head_i.addr);
  assign exec_idx = exec_ext[AW-1:0];
  assign head_idx = head_ext[AW-1:0];
  assign old_byte = exec_q.in_range ? rd_q : '0;
  assign sh       = ctrl_q[1:0];

  // magic write datapath
  always_comb begin
    nib = phase_q ? exec_q.data[3:0] : exec_q.data[7:4];
    pix = exec_q.data;
    if (ctrl_q[CTL_EXPAND]) begin
      for (int k = 0; k < 4; k++) begin
        pix[7-2*k -: 2] = nib[3-k] ? colors_q[3:2] : colors_q[1:0];
      end
    end
    if (ctrl_q[CTL_FLIP]) begin
      wide    = {{DATA_W{1'b0}}, reverse_pixels(pix)} << {sh, 1'b0};
      shifted = wide[7:0];
      spill   = wide[15:8];
    end else begin
      wide    = {pix, {DATA_W{1'b0}}} >> {sh, 1'b0};
      shifted = wide[15:8];
      spill   = wide[7:0];
    end
    merged = shifted | carry_q;

    coll_d = coll_q;
    if (ctrl_q[CTL_OR] || ctrl_q[CTL_XOR]) begin
      if ((merged != '0) && (old_byte != '0)) begin
        coll_d = COLL_HIT;
      end else begin
        coll_d = coll_q & COLL_KEEP;
      end
    end

    if (ctrl_q[CTL_XOR]) begin
      wr_byte = merged ^ old_byte;
    end else if (ctrl_q[CTL_OR]) begin
      wr_byte = merged | old_byte;
    end else begin
      wr_byte = merged;
    end

    wr_en  = 1'b0;
    result = '0;
    case (exec_q.kind)
      K_MAGIC: begin
        wr_en = exec_q.in_range;
      end
      K_RAM_WR: begin
        wr_en   = exec_q.in_range;
        wr_byte = exec_q.data;
      end
      K_RAM_RD: begin
        result = old_byte;
      end
      K_COLL_RD: begin
        result = coll_q;
      end
      default: begin
      end
    endcase
  end

  // RAM: clearing sweep after reset, then one read per accepted item and,
  // for in-range writes, one write as that item completes
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (done && wr_en) begin
      mem[exec_idx] <= wr_byte;
    end
    if (q_pop_o) begin
      rd_q <= mem[head_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q   <= 1'b1;
      clr_addr_q   <= '0;
      exec_valid_q <= 1'b0;
      ctrl_q       <= '0;
      colors_q     <= '0;
      phase_q      <= 1'b0;
      carry_q      <= '0;
      coll_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(RAM_BYTES - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end

      if (q_pop_o) begin
        exec_valid_q <= 1'b1;
      end else if (done) begin
        exec_valid_q <= 1'b0;
      end

      if (done) begin
        out_valid_q <= 1'b1;
        case (exec_q.kind)
          K_MAGIC: begin
            if (ctrl_q[CTL_EXPAND]) begin
              phase_q <= !phase_q;
            end
            carry_q <= spill;
            coll_q  <= coll_d;
          end
          K_CTRL_WR: begin
            ctrl_q  <= exec_q.data[CTRL_W-1:0];
            phase_q <= 1'b0;
            carry_q <= '0;
          end
          K_COLOR_WR: begin
            colors_q <= exec_q.data[COLOR_W-1:0];
          end
          K_COLL_RD: begin
            coll_q <= '0;
          end
          default: begin
          end
        endcase
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      exec_q <= q_head_i;
    end
    if (done) begin
      read_data_q <= result;
    end
  end

  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !q_pop_o)
    else $error("item taken during RAM clearing");

  a_pop_loads_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> exec_valid_q && !q_pop_o)
    else $error("exec stage not loaded or popped twice");

  a_exec_holds_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_valid_q && !done |=> exec_valid_q && $stable(rd_q))
    else $error("stalled exec lost its RAM byte");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(read_data_q))
    else $error("stalled result changed");

endmodule

@@ sim/magic_pixel_write_unit_test.sv @@
// Self-checking testbench of the magic pixel write unit: directed and random bus words.
module magic_pixel_write_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mpwu_pkg::*;

  localparam int unsigned RAM_BYTES = 16384;

  // spare op codes: the unit must ignore them and answer zero
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  localparam int unsigned TOTAL_WORDS    = 1875;
  localparam int unsigned DRAIN_EVERY    = 600;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned SETTLE_CYCLES  = 20;
  // reset sweep of the whole RAM plus long receiver hold, with margin
  localparam int unsigned WATCHDOG_LIMIT = 4 * RAM_BYTES;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    bit                drain;   // hold this word back until every result is in
  } bus_word_t;

  typedef struct {
    int unsigned       seq;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] read_data;
  } read_result_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [OP_W-1:0]     op_i         = '0;
  logic [ADDR_W-1:0]   address_i    = '0;
  logic [DATA_W-1:0]   write_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [DATA_W-1:0]   read_data_o;

  magic_pixel_write_unit #(
    .RAM_BYTES(RAM_BYTES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .address_i   (address_i),
    .write_data_i(write_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the unit's state, advanced once per accepted word.
  logic [DATA_W-1:0] shadow_vram [RAM_BYTES];
  logic [CTRL_W-1:0] shadow_ctrl;
  logic [COLOR_W-1:0] shadow_colors;
  logic              shadow_phase;
  logic [DATA_W-1:0] shadow_carry;
  logic [DATA_W-1:0] shadow_collision;

  bus_word_t    bus_words[$];        // words still to be offered
  read_result_t predicted_reads[$];  // results owed by the unit, oldest first

  bit          drain_next;
  int unsigned stimulus_count;
  int unsigned words_accepted;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  task automatic log_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic add_word(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] data);
    bus_word_t w;
    w.op = op;
    w.addr = addr;
    w.data = data;
    w.drain = drain_next;
    drain_next = 1'b0;
    bus_words.push_back(w);
    if (op != OP_SPARE6 && op != OP_SPARE7) stimulus_count++;
  endtask

  // Advance the shadow state by one bus word and return the byte it reads back.
  function automatic logic [DATA_W-1:0] apply_bus_word(input logic [OP_W-1:0] op,
                                                       input logic [ADDR_W-1:0] addr,
                                                       input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] pix;
    logic [DATA_W-1:0] mirrored;
    logic [DATA_W-1:0] spill;
    logic [DATA_W-1:0] old;
    logic [3:0]        nib;
    logic [15:0]       wide;
    logic [1:0]        shift;
    logic              in_ram;
    logic [DATA_W-1:0] rd;
    in_ram = (int'(addr) < RAM_BYTES);
    rd = '0;
    case (op)
      OP_MAGIC: begin
        shift = shadow_ctrl[1:0];
        pix = data;
        // expand: each nibble bit picks one of two colors, MSB lands leftmost
        if (shadow_ctrl[CTL_EXPAND]) begin
          nib = shadow_phase ? data[3:0] : data[7:4];
          for (int k = 0; k < 4; k++) pix[2*k +: 2] = nib[k] ? shadow_colors[3:2]
                                                           : shadow_colors[1:0];
          shadow_phase = ~shadow_phase;
        end
        if (shadow_ctrl[CTL_FLIP]) begin
          // mirror the pixel order, then shift toward bit 7
          for (int k = 0; k < 4; k++) mirrored[2*k +: 2] = pix[6-2*k +: 2];
          wide = {8'h00, mirrored} << (2 * shift);
          spill = wide[15:8];
          pix = wide[7:0];
        end else begin
          // shift toward bit 0; dropped pixels go to the top of the carry
          wide = {pix, 8'h00} >> (2 * shift);
          spill = wide[7:0];
          pix = wide[15:8];
        end
        pix = pix | shadow_carry;
        shadow_carry = spill;
        old = in_ram ? shadow_vram[addr] : '0;
        if (shadow_ctrl[CTL_OR] || shadow_ctrl[CTL_XOR]) begin
          if (pix != '0 && old != '0) shadow_collision = COLL_HIT;
          else shadow_collision = shadow_collision & COLL_KEEP;
        end
        if (shadow_ctrl[CTL_XOR]) pix = pix ^ old;
        else if (shadow_ctrl[CTL_OR]) pix = pix | old;
        if (in_ram) shadow_vram[addr] = pix;
      end
      OP_RAM_WR: begin
        if (in_ram) shadow_vram[addr] = data;
      end
      OP_RAM_RD: begin
        rd = in_ram ? shadow_vram[addr] : '0;
      end
      OP_CTRL_WR: begin
        shadow_ctrl = data[CTRL_W-1:0];
        shadow_phase = 1'b0;
        shadow_carry = '0;
      end
      OP_COLOR_WR: begin
        shadow_colors = data[COLOR_W-1:0];
      end
      OP_COLL_RD: begin
        rd = shadow_collision;
        shadow_collision = '0;
      end
      default: begin
      end
    endcase
    return rd;
  endfunction

  // Sender: offers queued words, idles a drawn number of cycles after each one.
  // Long runs of zero gaps alternate with runs of random gaps.
  always @(posedge clk_i or negedge rst_ni) begin : sender
    bus_word_t    w;
    read_result_t r;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      op_i         <= '0;
      address_i    <= '0;
      write_data_i <= '0;
      gap_left     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        r.seq = words_accepted;
        r.op = op_i;
        r.addr = address_i;
        r.read_data = apply_bus_word(op_i, address_i, write_data_i);
        predicted_reads.push_back(r);
        words_accepted++;
      end
      if (in_valid_i && in_stall_o) begin
        // stalled: payload and valid stay put
      end else if (gap_left != 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (bus_words.size() != 0 &&
                   (!bus_words[0].drain || predicted_reads.size() == 0)) begin
        w = bus_words.pop_front();
        op_i         <= w.op;
        address_i    <= w.addr;
        write_data_i <= w.data;
        in_valid_i   <= 1'b1;
        gap_left     <= ((words_accepted / 150) % 3 == 1) ? 0 : $urandom_range(0, 17);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: checks each result word against the oldest prediction and
  // stalls a drawn number of cycles after each one. Twice it holds off for a
  // long stretch so the front-end queue fills and the unit stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    read_result_t r;
    int unsigned  hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      hold = stall_left;
      if (out_valid_o && !out_stall_i) begin
        if (predicted_reads.size() == 0) begin
          log_mismatch($sformatf("read_data %h arrived with no word pending", read_data_o));
        end else begin
          r = predicted_reads.pop_front();
          if (read_data_o !== r.read_data)
            log_mismatch($sformatf("word %0d op %0d addr %h: read_data %h, predicted %h",
                                   r.seq, r.op, r.addr, read_data_o, r.read_data));
        end
        results_seen++;
        hold = ((results_seen / 130) % 3 == 2) ? 0 : $urandom_range(0, 17);
        if (results_seen == 500 || results_seen == 1300) hold = LONG_HOLD;
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= hold - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left  <= 0;
      end
    end
  end

  // Watchdog: too long without any word moving on either side ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned       sel;
    int unsigned       span;
    int unsigned       base;
    int unsigned       next_drain;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;

    foreach (shadow_vram[i]) shadow_vram[i] = '0;
    shadow_ctrl = '0;
    shadow_colors = '0;
    shadow_phase = 1'b0;
    shadow_carry = '0;
    shadow_collision = '0;

    // directed: RAM corners, both expand nibbles, every mode bit, spare ops
    add_word(OP_RAM_RD,   14'h0000, 8'h00);   // swept to zero at reset
    add_word(OP_RAM_WR,   14'h3fff, 8'hff);
    add_word(OP_RAM_RD,   14'h3fff, 8'h00);
    add_word(OP_COLOR_WR, 14'h0000, 8'hff);   // upper data bits ignored
    add_word(OP_CTRL_WR,  14'h0000, 8'h08);   // plain expand
    add_word(OP_MAGIC,    14'h0100, 8'ha5);   // high nibble
    add_word(OP_MAGIC,    14'h0101, 8'ha5);   // low nibble
    add_word(OP_CTRL_WR,  14'h0000, 8'h7f);   // all modes; XOR beats OR
    add_word(OP_COLOR_WR, 14'h0000, 8'h06);
    add_word(OP_MAGIC,    14'h0100, 8'hc3);
    add_word(OP_MAGIC,    14'h0100, 8'h3c);   // carry in, collision
    add_word(OP_COLL_RD,  14'h0000, 8'h00);
    add_word(OP_COLL_RD,  14'h0000, 8'h00);   // cleared by the read
    add_word(OP_CTRL_WR,  14'h0000, 8'h12);   // OR, shift by two
    add_word(OP_MAGIC,    14'h0200, 8'hff);
    add_word(OP_MAGIC,    14'h0200, 8'h00);   // only the carried pixels
    add_word(OP_CTRL_WR,  14'h0000, 8'h41);   // flip, shift by one
    add_word(OP_MAGIC,    14'h0300, 8'h1b);
    add_word(OP_MAGIC,    14'h0301, 8'h00);
    add_word(OP_RAM_RD,   14'h0301, 8'h00);
    add_word(OP_SPARE6,   14'h3fff, 8'hff);
    add_word(OP_SPARE7,   14'h2aaa, 8'h55);
    add_word(OP_CTRL_WR,  14'h0000, 8'h20);   // XOR only
    add_word(OP_MAGIC,    14'h3fff, 8'hff);   // clears the corner byte
    add_word(OP_COLL_RD,  14'h0000, 8'h00);

    // random: mostly draw sequences (colors, control, a run of magic writes
    // over a few neighboring bytes, read-backs), the rest plain traffic and noise
    drain_next = 1'b1;
    next_drain = stimulus_count + DRAIN_EVERY;
    while (stimulus_count < TOTAL_WORDS) begin
      if (stimulus_count >= next_drain) begin
        drain_next = 1'b1;
        next_drain += DRAIN_EVERY;
      end
      sel = $urandom_range(0, 15);
      if (sel <= 8) begin
        if ($urandom_range(0, 1) == 0) add_word(OP_COLOR_WR, ADDR_W'($urandom), 8'($urandom));
        add_word(OP_CTRL_WR, ADDR_W'($urandom), 8'($urandom));
        base = $urandom_range(0, RAM_BYTES - 1);
        span = $urandom_range(0, 3);
        repeat ($urandom_range(2, 8)) begin
          a = ADDR_W'(base + $urandom_range(0, span));
          d = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
          add_word(OP_MAGIC, a, d);
        end
        if ($urandom_range(0, 1) == 0) add_word(OP_RAM_RD, ADDR_W'(base), 8'($urandom));
        if ($urandom_range(0, 2) == 0) add_word(OP_COLL_RD, ADDR_W'($urandom), 8'($urandom));
      end else if (sel <= 10) begin
        a = ADDR_W'($urandom);
        add_word(OP_RAM_WR, a, 8'($urandom));
        add_word(OP_RAM_RD, a, 8'($urandom));
        add_word(OP_RAM_RD, ADDR_W'($urandom), 8'($urandom));
      end else if (sel == 11) begin
        add_word(OP_COLL_RD, ADDR_W'($urandom), 8'($urandom));
      end else if (sel == 12) begin
        add_word(OP_COLOR_WR, ADDR_W'($urandom), 8'($urandom));
      end else if (sel == 13) begin
        add_word(OP_CTRL_WR, ADDR_W'($urandom), 8'($urandom));
      end else begin
        add_word(OP_W'($urandom_range(0, 7)), ADDR_W'($urandom), 8'($urandom));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // run until every word is in and every owed result has come back
    @(posedge clk_i);
    while (bus_words.size() != 0 || in_valid_i || predicted_reads.size() != 0)
      @(posedge clk_i);
    // stray results would show up within the pipeline latency
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
